// ----- src/u16u8_pkg.sv -----
// shared types, constants and the bmp encode function for the utf-16 to utf-8 encoder
// used by every module in src; depends on nothing
package u16u8_pkg;

    localparam int MAX_BYTES   = 6;
    localparam int CNT_W       = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [20:0] SUPP_BASE  = 21'h010000;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      len;
    } seq3_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      last;
    } rec_t;

    typedef struct packed {
        logic held;
    } front_status_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] count;
    } back_status_t;

    function automatic seq3_t encode_bmp(input logic [15:0] cu);
        seq3_t s;
        s.bytes = '0;
        if (cu < 16'h0080) begin
            s.bytes[0] = {1'b0, cu[6:0]};
            s.len      = 2'd1;
        end
        else if (cu < 16'h0800) begin
            s.bytes[0] = LEAD2 | {3'b000, cu[10:6]};
            s.bytes[1] = CONT | {2'b00, cu[5:0]};
            s.len      = 2'd2;
        end
        else begin
            s.bytes[0] = LEAD3 | {4'b0000, cu[15:12]};
            s.bytes[1] = CONT | {2'b00, cu[11:6]};
            s.bytes[2] = CONT | {2'b00, cu[5:0]};
            s.len      = 2'd3;
        end
        return s;
    endfunction

endpackage

// ----- src/u16u8_front.sv -----
// front end: classifies each code unit, pairs surrogates, builds the byte record
// depends on u16u8_pkg
module u16u8_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [15:0]            code_unit,
    input  logic                   string_end,
    input  logic                   q_full,
    output logic                   q_push,
    output u16u8_pkg::rec_t        q_rec,
    output u16u8_pkg::front_status_t status
);

    logic       held_reg;
    logic       held_next;
    logic [9:0] high_bits_reg;
    logic [9:0] high_bits_next;

    logic               is_high;
    logic               is_low;
    logic               accept;
    logic [20:0]        cp;
    u16u8_pkg::seq3_t   seg;
    u16u8_pkg::seq3_t   repl;
    u16u8_pkg::rec_t    rec;

    assign is_high  = (code_unit >= u16u8_pkg::HIGH_FIRST) && (code_unit <= u16u8_pkg::HIGH_LAST);
    assign is_low   = (code_unit >= u16u8_pkg::LOW_FIRST) && (code_unit <= u16u8_pkg::LOW_LAST);
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cp       = {1'b0, high_bits_reg, code_unit[9:0]} + u16u8_pkg::SUPP_BASE;
    assign repl     = u16u8_pkg::encode_bmp(u16u8_pkg::REPLACEMENT);

    always_comb
    begin
        seg = '0;
        if (is_high && !string_end)
        begin
            seg.len = 2'd0;
        end
        else if (is_high || is_low)
        begin
            seg = u16u8_pkg::encode_bmp(u16u8_pkg::REPLACEMENT);
        end
        else
        begin
            seg = u16u8_pkg::encode_bmp(code_unit);
        end
    end

    always_comb
    begin
        rec      = '0;
        rec.last = string_end;
        if (held_reg && is_low)
        begin
            rec.bytes[0] = u16u8_pkg::LEAD4 | {5'b00000, cp[20:18]};
            rec.bytes[1] = u16u8_pkg::CONT | {2'b00, cp[17:12]};
            rec.bytes[2] = u16u8_pkg::CONT | {2'b00, cp[11:6]};
            rec.bytes[3] = u16u8_pkg::CONT | {2'b00, cp[5:0]};
            rec.count    = u16u8_pkg::CNT_W'(4);
        end
        else if (held_reg)
        begin
            rec.bytes[2:0] = repl.bytes;
            rec.bytes[5:3] = seg.bytes;
            rec.count      = u16u8_pkg::CNT_W'(3) + u16u8_pkg::CNT_W'(seg.len);
        end
        else
        begin
            rec.bytes[2:0] = seg.bytes;
            rec.count      = u16u8_pkg::CNT_W'(seg.len);
        end
    end

    always_comb
    begin
        held_next      = held_reg;
        high_bits_next = high_bits_reg;
        if (accept)
        begin
            if (is_high && !string_end && !(held_reg && is_low))
            begin
                held_next      = 1'b1;
                high_bits_next = code_unit[9:0];
            end
            else
            begin
                held_next      = 1'b0;
                high_bits_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 1'b0;
            high_bits_reg <= '0;
        end
        else
        begin
            held_reg      <= held_next;
            high_bits_reg <= high_bits_next;
        end
    end

    assign q_push      = accept && (rec.count != '0);
    assign q_rec       = rec;
    assign status.held = held_reg;

endmodule

// ----- src/u16u8_queue.sv -----
// short record queue between front and back ends
// depends on u16u8_pkg
module u16u8_queue #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u16u8_pkg::rec_t push_rec,
    output logic            full,
    output logic            head_valid,
    input  logic            pop,
    output u16u8_pkg::rec_t head_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u16u8_pkg::rec_t  entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;
    assign head_rec   = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/u16u8_back.sv -----
// back end: serializes one record into bytes, one per cycle while out_ready allows,
// into the output register; depends on u16u8_pkg
module u16u8_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  u16u8_pkg::rec_t        head_rec,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic                   run_last,
    output logic                   string_done,
    output u16u8_pkg::back_status_t status
);

    u16u8_pkg::rec_t               cur_reg;
    u16u8_pkg::rec_t               cur_next;
    logic                          busy_reg;
    logic                          busy_next;
    logic [u16u8_pkg::CNT_W-1:0]   idx_reg;
    logic [u16u8_pkg::CNT_W-1:0]   idx_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [7:0]                    out_byte_reg;
    logic [7:0]                    out_byte_next;
    logic                          run_last_reg;
    logic                          run_last_next;
    logic                          done_reg;
    logic                          done_next;

    logic advance;
    logic finishing;

    assign advance   = busy_reg && (!out_valid_reg || out_ready);
    assign finishing = (idx_reg == cur_reg.count - 1'b1);
    assign pop       = head_valid && (!busy_reg || (advance && finishing));

    always_comb
    begin
        cur_next       = cur_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        done_next      = done_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_reg.bytes[idx_reg];
            run_last_next  = finishing;
            done_next      = finishing && cur_reg.last;
            idx_next       = idx_reg + 1'b1;
            if (finishing)
            begin
                busy_next = 1'b0;
            end
        end
        if (pop)
        begin
            cur_next  = head_rec;
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
        done_reg     <= done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign run_last     = run_last_reg;
    assign string_done  = done_reg;
    assign status.busy  = busy_reg;
    assign status.idx   = idx_reg;
    assign status.count = cur_reg.count;

endmodule

// ----- src/utf16_to_utf8_encoder.sv -----
// path: queue entry, then serializer record register, then output byte register
// throughput: one code unit per cycle while the queue has room; the output side
// moves one byte per cycle while out_ready allows, so a unit yields 0 to 6 bytes
// reset: async active low; clears held surrogate, queue pointers and output valid
// top level: front end, record queue and byte serializer; depends on u16u8_pkg
module utf16_to_utf8_encoder #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] code_unit,
    input  logic        string_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        string_done
);

    logic                      q_full;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_head_valid;
    u16u8_pkg::rec_t           q_push_rec;
    u16u8_pkg::rec_t           q_head_rec;
    u16u8_pkg::front_status_t  front_status;
    u16u8_pkg::back_status_t   back_status;

    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_unit  (code_unit),
        .string_end (string_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_rec      (q_push_rec),
        .status     (front_status)
    );

    u16u8_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_rec   (q_push_rec),
        .full       (q_full),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .head_rec   (q_head_rec)
    );

    u16u8_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_head_valid),
        .head_rec    (q_head_rec),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_done (string_done),
        .status      (back_status)
    );

    a_done_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_done |-> run_last)
        else $error("string_done without run_last");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.busy |-> (back_status.idx < back_status.count))
        else $error("serializer index past record length");

    a_pair_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && front_status.held && code_unit[15:10] == 6'b110111
        |=> !front_status.held)
        else $error("surrogate pair left high surrogate held");

    a_end_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && string_end |=> !front_status.held)
        else $error("high surrogate held across string end");

endmodule

// ----- tb/sv/utf16_to_utf8_encoder_tb.sv -----
// testbench for utf16_to_utf8_encoder: directed table of code units, then random strings,
// every output byte checked, with random stalls, against typed row bytes or an in-bench
// utf-16 to utf-8 encoder; depends on u16u8_pkg and the utf16_to_utf8_encoder rtl
module utf16_to_utf8_encoder_tb;

    typedef struct packed {
        logic [7:0] value;
        logic       unit_last;
        logic       str_last;
    } utf8_byte_t;

    typedef struct packed {
        logic [15:0] unit;
        logic        str_end;
        logic        typed;
        logic [2:0]  count;
        logic [47:0] bytes;
    } unit_row_t;

    localparam int NUM_UNITS = 230;
    localparam int CALM_AFTER = 190;
    localparam int PAUSE_AT = 120;

    // typed rows: first byte in the top bits of bytes
    localparam unit_row_t UNIT_ROWS [24] = '{
        '{16'h0000, 1'b0, 1'b1, 3'd1, {8'h00, 40'h0}},
        '{16'h007F, 1'b0, 1'b1, 3'd1, {8'h7F, 40'h0}},
        '{16'h0080, 1'b0, 1'b1, 3'd2, {16'hC280, 32'h0}},
        '{16'h07FF, 1'b0, 1'b1, 3'd2, {16'hDFBF, 32'h0}},
        '{16'h0800, 1'b0, 1'b1, 3'd3, {24'hE0A080, 24'h0}},
        '{16'hFFFF, 1'b1, 1'b1, 3'd3, {24'hEFBFBF, 24'h0}},
        '{16'hDC00, 1'b0, 1'b1, 3'd3, {24'hEFBFBD, 24'h0}},
        '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0},
        '{16'hDC00, 1'b0, 1'b1, 3'd4, {32'hF0908080, 16'h0}},
        '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h0},
        '{16'hDFFF, 1'b1, 1'b1, 3'd4, {32'hF48FBFBF, 16'h0}},
        '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0},
        '{16'h0041, 1'b0, 1'b1, 3'd4, {32'hEFBFBD41, 16'h0}},
        '{16'hDBFF, 1'b1, 1'b1, 3'd3, {24'hEFBFBD, 24'h0}},
        '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0},
        '{16'hDBFF, 1'b1, 1'b1, 3'd6, 48'hEFBFBDEFBFBD},
        '{16'hD801, 1'b0, 1'b1, 3'd0, 48'h0},
        '{16'hD802, 1'b0, 1'b1, 3'd3, {24'hEFBFBD, 24'h0}},
        '{16'hDFFF, 1'b1, 1'b1, 3'd4, {32'hF090AFBF, 16'h0}},
        '{16'h5A5A, 1'b0, 1'b0, 3'd0, 48'h0},
        '{16'h0000, 1'b1, 1'b1, 3'd1, {8'h00, 40'h0}},
        '{16'hE000, 1'b0, 1'b0, 3'd0, 48'h0},
        '{16'hD7FF, 1'b1, 1'b0, 3'd0, 48'h0},
        '{16'hA5A5, 1'b1, 1'b0, 3'd0, 48'h0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] code_unit = '0;
    logic        string_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        string_done;

    utf8_byte_t  pending_bytes[$];
    logic [9:0]  held_surrogate_bits = '0;
    logic        surrogate_held = 1'b0;
    int          sent_units = 0;
    int          errors = 0;
    bit          idling = 1'b1;
    int          stall_left = 0;

    utf16_to_utf8_encoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .code_unit   (code_unit),
        .string_end  (string_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_done (string_done)
    );

    always #5 clk = ~clk;

    function automatic void add_point(input logic [20:0] cp, inout int n,
                                      inout logic [47:0] seq);
        logic [31:0] enc;
        int          len;
        if (cp < 21'h80) begin
            enc = {cp[7:0], 24'h0};
            len = 1;
        end
        else if (cp < 21'h800) begin
            enc = {u16u8_pkg::LEAD2 | {3'b000, cp[10:6]},
                   u16u8_pkg::CONT | {2'b00, cp[5:0]}, 16'h0};
            len = 2;
        end
        else if (cp < 21'h10000) begin
            enc = {u16u8_pkg::LEAD3 | {4'b0000, cp[15:12]},
                   u16u8_pkg::CONT | {2'b00, cp[11:6]},
                   u16u8_pkg::CONT | {2'b00, cp[5:0]}, 8'h0};
            len = 3;
        end
        else begin
            enc = {u16u8_pkg::LEAD4 | {5'b00000, cp[20:18]},
                   u16u8_pkg::CONT | {2'b00, cp[17:12]},
                   u16u8_pkg::CONT | {2'b00, cp[11:6]},
                   u16u8_pkg::CONT | {2'b00, cp[5:0]}};
            len = 4;
        end
        seq = seq | ({enc, 16'h0} >> (8 * n));
        n = n + len;
    endfunction

    function automatic void encode_unit(input logic [15:0] cu, input logic str_end,
                                        output int n, output logic [47:0] seq);
        logic is_high;
        logic is_low;
        is_high = cu >= u16u8_pkg::HIGH_FIRST && cu <= u16u8_pkg::HIGH_LAST;
        is_low = cu >= u16u8_pkg::LOW_FIRST && cu <= u16u8_pkg::LOW_LAST;
        n = 0;
        seq = '0;
        if (surrogate_held && is_low) begin
            add_point(u16u8_pkg::SUPP_BASE + {1'b0, held_surrogate_bits, cu[9:0]}, n, seq);
            surrogate_held = 1'b0;
            held_surrogate_bits = '0;
        end
        else begin
            if (surrogate_held) begin
                add_point({5'b0, u16u8_pkg::REPLACEMENT}, n, seq);
                surrogate_held = 1'b0;
                held_surrogate_bits = '0;
            end
            if (is_high && !str_end) begin
                held_surrogate_bits = cu[9:0];
                surrogate_held = 1'b1;
            end
            else if (is_high || is_low) begin
                add_point({5'b0, u16u8_pkg::REPLACEMENT}, n, seq);
            end
            else begin
                add_point({5'b0, cu}, n, seq);
            end
        end
    endfunction

    function automatic void queue_bytes(input int n, input logic [47:0] seq,
                                        input logic str_end);
        utf8_byte_t b;
        for (int i = 0; i < n; i++) begin
            b = {seq[47 - 8 * i -: 8], i == n - 1, (i == n - 1) && str_end};
            pending_bytes.insert(pending_bytes.size(), b);
        end
    endfunction

    task automatic send_unit(input logic [15:0] cu, input logic str_end);
        if (idling && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        code_unit <= cu;
        string_end <= str_end;
        do @(posedge clk); while (!in_ready);
        sent_units++;
    endtask

    task automatic send_checked(input logic [15:0] cu, input logic str_end);
        int          n;
        logic [47:0] seq;
        send_unit(cu, str_end);
        encode_unit(cu, str_end, n, seq);
        queue_bytes(n, seq, str_end);
    endtask

    task automatic drain_output();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_bytes.size() != 0);
    endtask

    // mostly well-formed strings, some lone or unpaired surrogates and open-ended strings
    task automatic send_random_string();
        logic [15:0] units[$];
        int          len;
        int          pick;
        bit          closes;
        len = $urandom_range(1, 8);
        while (units.size() < len) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                units.insert(units.size(), 16'($urandom_range(16'h0000, 16'h007F)));
            else if (pick < 45)
                units.insert(units.size(), 16'($urandom_range(16'h0080, 16'h07FF)));
            else if (pick < 55)
                units.insert(units.size(), 16'($urandom_range(16'h0800, 16'hD7FF)));
            else if (pick < 65)
                units.insert(units.size(), 16'($urandom_range(16'hE000, 16'hFFFF)));
            else if (pick < 85) begin
                units.insert(units.size(), 16'($urandom_range(u16u8_pkg::HIGH_FIRST,
                                                              u16u8_pkg::HIGH_LAST)));
                units.insert(units.size(), 16'($urandom_range(u16u8_pkg::LOW_FIRST,
                                                              u16u8_pkg::LOW_LAST)));
            end
            else if (pick < 90)
                units.insert(units.size(), 16'($urandom_range(u16u8_pkg::LOW_FIRST,
                                                              u16u8_pkg::LOW_LAST)));
            else if (pick < 95)
                units.insert(units.size(), 16'($urandom_range(u16u8_pkg::HIGH_FIRST,
                                                              u16u8_pkg::HIGH_LAST)));
            else
                units.insert(units.size(), 16'($urandom));
        end
        closes = $urandom_range(0, 9) != 0;
        for (int i = 0; i < units.size(); i++)
            send_checked(units[i], closes && i == units.size() - 1);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready <= stall_left == 1;
        end
        else if (idling && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 8);
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : byte_check
        utf8_byte_t got;
        utf8_byte_t want;
        if (rst_n && out_valid && out_ready) begin
            got = {out_byte, run_last, string_done};
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected byte %h run_last %b string_done %b",
                         $time, got.value, got.unit_last, got.str_last);
                errors++;
            end
            else begin
                want = pending_bytes.pop_front();
                if (got !== want) begin
                    $display("%0t: byte expected %h/%b/%b actual %h/%b/%b", $time,
                             want.value, want.unit_last, want.str_last,
                             got.value, got.unit_last, got.str_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        int          n;
        logic [47:0] seq;
        bit          paused;
        paused = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < $size(UNIT_ROWS); i++) begin
            send_unit(UNIT_ROWS[i].unit, UNIT_ROWS[i].str_end);
            encode_unit(UNIT_ROWS[i].unit, UNIT_ROWS[i].str_end, n, seq);
            if (UNIT_ROWS[i].typed)
                queue_bytes(UNIT_ROWS[i].count, UNIT_ROWS[i].bytes, UNIT_ROWS[i].str_end);
            else
                queue_bytes(n, seq, UNIT_ROWS[i].str_end);
        end
        drain_output();
        while (sent_units < NUM_UNITS) begin
            if (!paused && sent_units >= PAUSE_AT) begin
                drain_output();
                paused = 1'b1;
            end
            if (sent_units >= CALM_AFTER)
                idling = 1'b0;
            send_random_string();
        end
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
